>>> rtl/unf_pkg.sv
// Package with the shared types and constants of the unsigned number formatter.
package unf_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  localparam logic [1:0] RADIX_DEC    = 2'd0;
  localparam logic [1:0] RADIX_HEX_LO = 2'd1;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_PLAN,
    ST_EMIT
  } unf_state_t;

endpackage

>>> rtl/unsigned_number_formatter.sv
// Unsigned number formatter top level: printf-style %u / %x / %X text, one character per beat.
// A decimal item runs the bit-serial BCD conversion (one shift per value bit, then its done
// flag), then the count and plan states before its first character; a hex item skips it.
// One item at a time, N characters per item (at least one beat); the output register gives
// one character beat per cycle while the receiver does not stall it.
// Reset (rst, synchronous): returns to idle and drops the output beat; no clearing pass.
module unsigned_number_formatter import unf_pkg::*; #(
  parameter int MAX_FIELD = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic [1:0]         radix_mode,
  input  logic [5:0]         field_width,
  input  logic [6:0]         precision,
  input  logic               left_align,
  input  logic               zero_pad,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               last,
  output logic               empty_res,
  output logic [5:0]         total_count
);

  // Counts of characters never exceed MAX_FIELD, so this width holds all of them.
  localparam int CW = $clog2(MAX_FIELD + 1);

  unf_state_t state, state_next;

  // Captured item fields.
  logic [1:0]  radix_r;
  logic [5:0]  width_r;
  logic [6:0]  prec_r;
  logic        left_r;
  logic        zpad_r;
  logic        zero_val;
  digits_t     digits;

  // Plan of the conversion, built once the digits are known.
  logic [3:0]    nd;
  logic [CW-1:0] zeros;
  logic [CW-1:0] body;
  logic [CW-1:0] pad;
  logic [CW-1:0] total;
  logic [CW-1:0] pos;

  logic    in_fire;
  logic    bcd_start;
  logic    bcd_done;
  digits_t bcd_digits;
  logic    emit_go;

  assign in_fire = in_valid && !in_stall;

  unf_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .value  (value),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (radix_mode == RADIX_DEC) ? ST_CONVERT : ST_COUNT;
        end
      end
      ST_CONVERT: begin
        if (bcd_done) state_next = ST_COUNT;
      end
      ST_COUNT: state_next = ST_PLAN;
      ST_PLAN:  state_next = ST_EMIT;
      ST_EMIT: begin
        // Leaves after loading the final beat; an empty conversion has one beat.
        if (emit_go && ((total == '0) || (CW'(pos + 1'b1) == total))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs. The input side is open only when idle; the output register lets the
  // next item be taken while the last beat of the previous one still waits.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    bcd_start = (state == ST_IDLE) && in_fire && (radix_mode == RADIX_DEC);
    emit_go   = (state == ST_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item. Hex digits are simply the nibbles of the value.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      radix_r  <= radix_mode;
      width_r  <= field_width;
      prec_r   <= precision;
      left_r   <= left_align;
      zpad_r   <= zero_pad;
      zero_val <= (value == '0);
    end
    if (in_fire && (radix_mode != RADIX_DEC)) begin
      digits <= digits_t'({8'h00, value});
    end else if (bcd_done) begin
      digits <= bcd_digits;
    end
  end

  // Significant digit count: position of the highest nonzero digit, at least one.
  function automatic logic [3:0] count_digits(digits_t d);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (d[i] != 4'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Plan arithmetic. A negative precision counts as absent; width and precision both
  // saturate at MAX_FIELD. A zero value with precision zero prints no digits at all.
  logic          prec_given;
  logic [CW-1:0] prec_sat;
  logic [CW-1:0] width_sat;
  logic [CW-1:0] nd_eff;
  logic [CW-1:0] zeros_calc;
  logic [CW-1:0] body_calc;
  logic [CW-1:0] pad_calc;

  always_comb begin
    prec_given = !prec_r[6];
    prec_sat   = (int'(prec_r[5:0]) > MAX_FIELD) ? CW'(MAX_FIELD) : CW'(prec_r[5:0]);
    width_sat  = (int'(width_r) > MAX_FIELD) ? CW'(MAX_FIELD) : CW'(width_r);
    nd_eff     = (prec_given && (prec_sat == '0) && zero_val) ? '0 : CW'(nd);
    zeros_calc = (prec_given && (prec_sat > nd_eff)) ? prec_sat - nd_eff : '0;
    body_calc  = nd_eff + zeros_calc;
    pad_calc   = (width_sat > body_calc) ? width_sat - body_calc : '0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_COUNT) begin
      nd <= count_digits(digits);
    end
    if (state == ST_PLAN) begin
      zeros <= zeros_calc;
      body  <= body_calc;
      pad   <= pad_calc;
      total <= body_calc + pad_calc;
      pos   <= '0;
    end else if (emit_go) begin
      pos <= pos + 1'b1;
    end
  end

  // Character at the current position. Right-aligned text is pad, zeros, digits;
  // left-aligned text is zeros, digits, pad. Digits come out most significant first.
  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + 8'(d);
    end else if (upper) begin
      c = CHAR_UPPER_A + 8'(d - 4'd10);
    end else begin
      c = CHAR_LOWER_A + 8'(d - 4'd10);
    end
    return c;
  endfunction

  logic [7:0]    pad_char;
  logic [7:0]    cur_char;
  logic [CW-1:0] dig_idx;
  logic          beat_last;
  logic          beat_empty;

  always_comb begin
    pad_char   = zpad_r ? CHAR_ZERO : CHAR_SPACE;
    dig_idx    = left_r ? (body - 1'b1 - pos) : (total - 1'b1 - pos);
    beat_empty = (total == '0);
    beat_last  = beat_empty || (CW'(pos + 1'b1) == total);
    if (beat_empty) begin
      cur_char = CHAR_NONE;
    end else if (!left_r) begin
      if (pos < pad) begin
        cur_char = pad_char;
      end else if (pos < CW'(pad + zeros)) begin
        cur_char = CHAR_ZERO;
      end else begin
        cur_char = digit_char(digits[dig_idx[3:0]], radix_r != RADIX_HEX_LO);
      end
    end else begin
      if (pos < zeros) begin
        cur_char = CHAR_ZERO;
      end else if (pos < body) begin
        cur_char = digit_char(digits[dig_idx[3:0]], radix_r != RADIX_HEX_LO);
      end else begin
        cur_char = pad_char;
      end
    end
  end

  // Output register: holds a beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_char    <= cur_char;
      last        <= beat_last;
      empty_res   <= beat_empty;
      total_count <= beat_last ? 6'(total) : 6'd0;
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && (total_count == 6'd0))
    else $error("empty beat not marked as the last one");

  a_count_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (total_count == 6'd0))
    else $error("character count on a beat that is not the last");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_CONVERT) || (state == ST_COUNT))
    else $error("accepted item did not start a conversion");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && (total != '0) |-> (pos < total))
    else $error("emit position ran past the end of the text");

endmodule

>>> rtl/unf_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module unf_bcd import unf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               done,
  output digits_t            digits
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] shreg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  digits_t            adjusted;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adjusted[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(VALUE_W - 1));
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      shreg  <= value;
      digits <= '0;
    end else if (busy) begin
      {digits, shreg} <= {adjusted, shreg} << 1;
    end
  end

  function automatic logic all_bcd(digits_t d);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (d[i] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("conversion done without a running conversion");

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    done |-> all_bcd(digits))
    else $error("converted digit out of decimal range");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt != CNT_W'(VALUE_W - 1)) |=> busy)
    else $error("conversion stopped early");

endmodule

>>> tb/unsigned_number_formatter_tb.sv
// Self-checking testbench for the unsigned number formatter: directed table, random beats, stalls.
module unsigned_number_formatter_tb import unf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The block's field cap. Width and precision saturate here.
  localparam int FIELD_CAP = 63;

  // The package names only the decimal and lower-case hex codes. The remaining two radix
  // codes are named here: code two is upper-case hex, and code three also prints upper case.
  localparam logic [1:0] RADIX_HEX_UP = 2'd2;
  localparam logic [1:0] RADIX_SPARE  = 2'd3;

  // Precision codes. All ones is the usual "not given" code. The most negative code must
  // also act as "not given".
  localparam logic [6:0] PREC_NONE    = 7'h7F;
  localparam logic [6:0] PREC_MOST_NEG = 7'h40;

  localparam int RANDOM_ITEMS = 127;
  // The longest time with no beat on either side before the run is declared hung. A decimal
  // item waits for its BCD conversion before its first character. The receiver's longest hold-off
  // is HOLD_CYCLES. The limit sits far above both.
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 60;
  localparam int STALL_LIMIT  = 2000;
  // After the last expected character, run on through the drain window. Any
  // stray beat that shows up in that window is caught.
  localparam int DRAIN_CYCLES = 64;

  // One conversion request. When 'typed' is set, 'text' holds the expected output string,
  // written by hand. Otherwise the predictor works out the text.
  typedef struct {
    logic [31:0] val;
    logic [1:0]  radix;
    logic [5:0]  width;
    logic [6:0]  prec;
    logic        left;
    logic        zpad;
    bit          typed;
    string       text;
  } fmt_row_t;

  // One expected output beat.
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       none;
    logic [5:0] count;
  } char_beat_t;

  // These are the receiver's stall styles. A new one is drawn at random whenever the style
  // age counter wraps to zero.
  typedef enum logic [1:0] {
    FLOW_FREE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD
  } stall_style_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [31:0] value       = '0;
  logic [1:0]  radix_mode  = '0;
  logic [5:0]  field_width = '0;
  logic [6:0]  precision   = '0;
  logic        left_align  = 1'b0;
  logic        zero_pad    = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  out_char;
  logic        last;
  logic        empty_res;
  logic [5:0]  total_count;

  // This queue holds the characters still owed by the block, oldest first, across all
  // conversions in flight.
  char_beat_t chars_due[$];
  int         mismatches     = 0;
  int         chars_checked  = 0;
  int         items_accepted = 0;
  int         burst_left     = 0;
  logic       hold_out       = 1'b0;

  unsigned_number_formatter #(
    .MAX_FIELD(FIELD_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .radix_mode(radix_mode),
    .field_width(field_width),
    .precision(precision),
    .left_align(left_align),
    .zero_pad(zero_pad),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .last(last),
    .empty_res(empty_res),
    .total_count(total_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // This is the directed table. The rows cover the field extremes, every radix code, and
  // both flags in every combination that matters. It also covers the special cases: a zero
  // value with zero precision (no digits, with and without padding), negative precision
  // codes, the spare radix code, zero padding on the left-aligned side, and fields at the
  // cap. The four rows at the cap give long strings, so the predictor checks them. Every
  // other row has its expected text written out.
  fmt_row_t directed_rows[$] = '{
    '{32'd0,          RADIX_DEC,    6'd0,  PREC_NONE,     1'b0, 1'b0, 1'b1, "0"},
    '{32'd0,          RADIX_DEC,    6'd0,  7'd0,          1'b0, 1'b0, 1'b1, ""},
    '{32'd0,          RADIX_DEC,    6'd5,  7'd0,          1'b0, 1'b0, 1'b1, "     "},
    '{32'd0,          RADIX_HEX_LO, 6'd4,  7'd0,          1'b1, 1'b1, 1'b1, "0000"},
    '{32'hFFFF_FFFF,  RADIX_DEC,    6'd0,  PREC_NONE,     1'b0, 1'b0, 1'b1, "4294967295"},
    '{32'hFFFF_FFFF,  RADIX_HEX_LO, 6'd0,  PREC_NONE,     1'b0, 1'b0, 1'b1, "ffffffff"},
    '{32'hFFFF_FFFF,  RADIX_HEX_UP, 6'd0,  PREC_NONE,     1'b0, 1'b0, 1'b1, "FFFFFFFF"},
    '{32'hABCD_EF01,  RADIX_SPARE,  6'd0,  PREC_NONE,     1'b0, 1'b0, 1'b1, "ABCDEF01"},
    '{32'd42,         RADIX_DEC,    6'd8,  PREC_NONE,     1'b1, 1'b0, 1'b1, "42      "},
    '{32'd42,         RADIX_DEC,    6'd8,  PREC_NONE,     1'b0, 1'b1, 1'b1, "00000042"},
    '{32'd42,         RADIX_DEC,    6'd6,  PREC_NONE,     1'b1, 1'b1, 1'b1, "420000"},
    '{32'd42,         RADIX_DEC,    6'd0,  7'd5,          1'b0, 1'b0, 1'b1, "00042"},
    '{32'd42,         RADIX_DEC,    6'd8,  7'd5,          1'b0, 1'b0, 1'b1, "   00042"},
    '{32'd0,          RADIX_DEC,    6'd0,  PREC_MOST_NEG, 1'b0, 1'b0, 1'b1, "0"},
    '{32'd7,          RADIX_DEC,    6'd3,  7'h7B,         1'b0, 1'b0, 1'b1, "  7"},
    '{32'h8000_0000,  RADIX_DEC,    6'd0,  PREC_NONE,     1'b0, 1'b0, 1'b1, "2147483648"},
    '{32'd1234567890, RADIX_HEX_LO, 6'd0,  PREC_NONE,     1'b0, 1'b0, 1'b1, "499602d2"},
    '{32'd0,          RADIX_HEX_LO, 6'd0,  7'd2,          1'b0, 1'b0, 1'b1, "00"},
    '{32'hFFFF_FFFF,  RADIX_DEC,    6'd9,  7'd0,          1'b0, 1'b1, 1'b1, "4294967295"},
    '{32'd1,          RADIX_DEC,    6'd63, PREC_NONE,     1'b0, 1'b0, 1'b0, ""},
    '{32'hFFFF_FFFF,  RADIX_HEX_LO, 6'd0,  7'd63,         1'b0, 1'b0, 1'b0, ""},
    '{32'd12345,      RADIX_DEC,    6'd63, 7'd63,         1'b1, 1'b1, 1'b0, ""},
    '{32'd0,          RADIX_HEX_UP, 6'd63, 7'd0,          1'b1, 1'b0, 1'b0, ""}
  };

  // This is the predictor. It builds the text that one conversion must produce. The digits
  // are worked out least significant first. Then the text is put together as: width padding
  // before the number, zeros up to the precision, the digits, and width padding after the
  // number. A negative precision counts as "not given". A zero value with zero precision
  // gives no digits at all.
  function automatic string format_text(input fmt_row_t r);
    logic [7:0]  digit_chars [10];
    logic [7:0]  pad_char;
    logic [31:0] rest;
    logic [31:0] base;
    logic [31:0] d;
    int          width_eff;
    int          prec_eff;
    int          n_dig;
    int          zero_len;
    int          body_len;
    int          pad_len;
    int          i;
    string       text;
    rest      = r.val;
    base      = (r.radix == RADIX_DEC) ? 32'd10 : 32'd16;
    width_eff = (int'(r.width) > FIELD_CAP) ? FIELD_CAP : int'(r.width);
    prec_eff  = $signed(r.prec);
    if (prec_eff > FIELD_CAP) prec_eff = FIELD_CAP;
    pad_char = r.zpad ? CHAR_ZERO : CHAR_SPACE;
    n_dig = 0;
    do begin
      d = rest % base;
      if (d < 32'd10) begin
        digit_chars[n_dig] = CHAR_ZERO + d[7:0];
      end else begin
        digit_chars[n_dig] = ((r.radix == RADIX_HEX_LO) ? CHAR_LOWER_A : CHAR_UPPER_A)
                             + d[7:0] - 8'd10;
      end
      n_dig++;
      rest = rest / base;
    end while (rest != 32'd0);
    if (prec_eff == 0 && r.val == 32'd0) n_dig = 0;
    zero_len = (prec_eff > n_dig) ? prec_eff - n_dig : 0;
    body_len = (prec_eff > n_dig) ? prec_eff : n_dig;
    pad_len  = (width_eff > body_len) ? width_eff - body_len : 0;
    text = "";
    if (!r.left) for (i = 0; i < pad_len; i++) text = $sformatf("%s%c", text, pad_char);
    for (i = 0; i < zero_len; i++) text = $sformatf("%s%c", text, CHAR_ZERO);
    for (i = n_dig - 1; i >= 0; i--) text = $sformatf("%s%c", text, digit_chars[i]);
    if (r.left) for (i = 0; i < pad_len; i++) text = $sformatf("%s%c", text, pad_char);
    return text;
  endfunction

  // This turns one conversion's text into the beats the block owes. The final beat has 'last'
  // set and carries the character count. An empty text stands for a single beat that is
  // flagged empty, with a zero character.
  function automatic void queue_text(input string text);
    char_beat_t b;
    int         i;
    if (text.len() == 0) begin
      b = '{CHAR_NONE, 1'b1, 1'b1, 6'd0};
      chars_due.push_back(b);
      return;
    end
    for (i = 0; i < text.len(); i++) begin
      b.ch    = text[i];
      b.fin   = (i == text.len() - 1);
      b.none  = 1'b0;
      b.count = b.fin ? 6'(text.len()) : 6'd0;
      chars_due.push_back(b);
    end
  endfunction

  // Prints one mismatch line and counts the mismatch. Printing stops after a hundred lines,
  // so a badly broken block cannot flood the log, but the count goes on.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 100) begin
      $display("%0t: beat %0d: %s: got 'h%0h, want 'h%0h", $realtime, chars_checked, what,
               got, want);
    end
    mismatches++;
  endtask

  // Compares one accepted output beat, field by field, with the oldest expected beat.
  task automatic check_char();
    char_beat_t want;
    if (chars_due.size() == 0) begin
      flag_mismatch("character beat with nothing expected", {24'd0, out_char}, 32'd0);
      chars_checked++;
      return;
    end
    want = chars_due.pop_front();
    if (out_char !== want.ch)
      flag_mismatch("out_char", 32'(out_char), 32'(want.ch));
    if (last !== want.fin)
      flag_mismatch("last", 32'(last), 32'(want.fin));
    if (empty_res !== want.none)
      flag_mismatch("empty_res", 32'(empty_res), 32'(want.none));
    if (total_count !== want.count)
      flag_mismatch("total_count", 32'(total_count), 32'(want.count));
    chars_checked++;
  endtask

  // Random requests. The value is a full random word two times in five. Small values and zero
  // come often enough to reach the cases with no digits and with heavy padding. Width and
  // precision stay small most of the time, so long strings do not take over the run. They
  // still reach the cap now and then. Precision sometimes takes any 7-bit code, negative
  // codes included.
  function automatic fmt_row_t random_row();
    fmt_row_t r;
    case ($urandom_range(0, 4))
      0:       r.val = $urandom_range(0, 255);
      1:       r.val = 32'd0;
      2:       r.val = 32'd1 << $urandom_range(0, 31);
      default: r.val = $urandom;
    endcase
    r.radix = 2'($urandom_range(0, 3));
    r.width = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 12)) : 6'($urandom_range(0, 63));
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: r.prec = PREC_NONE;
      8, 9:                   r.prec = 7'd0;
      10, 11, 12:             r.prec = 7'($urandom_range(0, 127));
      default:                r.prec = 7'($urandom_range(1, 12));
    endcase
    r.left  = 1'($urandom_range(0, 1));
    r.zpad  = 1'($urandom_range(0, 1));
    r.typed = 1'b0;
    r.text  = "";
    return r;
  endfunction

  // Presents one request and holds it until the block takes it. The expected characters are
  // queued at the edge that accepts the request. The first character comes only after the
  // count and plan states, so queuing them at this edge cannot race the checker.
  task automatic offer(input fmt_row_t r);
    in_valid    <= 1'b1;
    value       <= r.val;
    radix_mode  <= r.radix;
    field_width <= r.width;
    precision   <= r.prec;
    left_align  <= r.left;
    zero_pad    <= r.zpad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_text(r.typed ? r.text : format_text(r));
    items_accepted++;
  endtask

  // The sender works in bursts. Inside a burst, requests follow back to back. When a burst
  // ends, valid drops for a short gap or, now and then, a long one. The gap is never empty,
  // so valid is never lowered and raised within the same step.
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // The stimulus process. It runs reset, then the directed table, then the random requests,
  // then the drain, and then gives the verdict.
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 20);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i]);
      pace();
    end
    repeat (RANDOM_ITEMS) begin
      offer(random_row());
      pace();
    end
    in_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("unsigned_number_formatter_tb: done, clean");
    end else begin
      $display("unsigned_number_formatter_tb: done, errors");
    end
    $finish;
  end

  // The receiver and the checker. The beat accepted at this edge is checked first. Then the
  // stall for the next cycle is chosen, from the current style or from the long hold-off.
  always @(posedge clk) begin : receiver
    logic         pick;
    stall_style_t style_now;
    logic [5:0]   style_age;
    logic [1:0]   third;
    if (!rst && out_valid && !out_stall) check_char();
    if (rst) begin
      style_now = FLOW_FREE;
      style_age = '0;
      third     = '0;
    end else begin
      style_age = style_age + 6'd1;
      if (style_age == 6'd0) style_now = stall_style_t'($urandom_range(0, 3));
      third = (third == 2'd2) ? 2'd0 : third + 2'd1;
    end
    case (style_now)
      FLOW_FREE:         pick = 1'b0;
      STALL_LIGHT:       pick = ($urandom_range(0, 3) == 0);
      STALL_HEAVY:       pick = ($urandom_range(0, 3) != 0);
      STALL_EVERY_THIRD: pick = (third == 2'd0);
      default:           pick = 1'b0;
    endcase
    out_stall <= hold_out || pick;
  end

  // This is one long hold-off on the output, partway through the random part. The sender
  // keeps offering requests during it. The block fills up and must hold its input stalled
  // until the receiver lets go.
  initial begin : long_hold
    wait (items_accepted >= HOLD_AFTER);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  // The watchdog counts cycles in which neither side accepts a beat. If the count reaches
  // the limit, the run is declared hung. This also covers expected characters that never
  // arrive.
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("%0t: no beat for %0d cycles, %0d characters still expected", $realtime,
             STALL_LIMIT, chars_due.size());
    $display("unsigned_number_formatter_tb: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/unf_pkg.sv
rtl/unf_bcd.sv
rtl/unsigned_number_formatter.sv
tb/unsigned_number_formatter_tb.sv
